/* rtl/slwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_pkg
// Shared types and constants of the sliding window minimizer selector.
// ----------------------------------------------------------------------------
package slwm_pkg;

  localparam int HASH_W = 56;
  localparam int LOW_W  = 8;
  localparam int TAG_W  = 64;
  localparam int CFG_W  = 6;

  localparam logic [CFG_W-1:0] CFG_RESET    = CFG_W'(16);
  localparam logic [TAG_W-1:0] TAG_ALL_ONES = {TAG_W{1'b1}};

  // One ring entry: hash, low byte and position tag.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [LOW_W-1:0]  low;
    logic [TAG_W-1:0]  tag;
  } slwm_item_t;

  localparam int ITEM_W = $bits(slwm_item_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE
  } slwm_state_e;

endpackage

/* rtl/slwm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_in_if
// Input word channel: one hashed item per word.
// ----------------------------------------------------------------------------
interface slwm_in_if;
  import slwm_pkg::*;

  logic              valid;
  logic              ready;
  logic              first_of_sequence;
  logic [HASH_W-1:0] hash_value;
  logic [LOW_W-1:0]  low_byte;
  logic [TAG_W-1:0]  position_tag;

  modport source (
    output valid, first_of_sequence, hash_value, low_byte, position_tag,
    input  ready
  );
  modport sink (
    input  valid, first_of_sequence, hash_value, low_byte, position_tag,
    output ready
  );
endinterface

/* rtl/slwm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_out_if
// Result word channel: the selected window minimum.
// ----------------------------------------------------------------------------
interface slwm_out_if;
  import slwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] min_hash;
  logic [LOW_W-1:0]  min_low_byte;
  logic [TAG_W-1:0]  min_position_tag;

  modport source (
    output valid, min_hash, min_low_byte, min_position_tag,
    input  ready
  );
  modport sink (
    input  valid, min_hash, min_low_byte, min_position_tag,
    output ready
  );
endinterface

/* rtl/slwm_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_cfg_if
// Configuration write channel carrying the window size.
// ----------------------------------------------------------------------------
interface slwm_cfg_if;
  import slwm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_size;

  modport source (
    output valid, window_size,
    input  ready
  );
  modport sink (
    input  valid, window_size,
    output ready
  );
endinterface

/* rtl/slwm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_front
// Accepts input words, tracks ring pointer and fill count, and tags each
// word with its ring slot, window size and whether it triggers a scan.
// ----------------------------------------------------------------------------
module slwm_front
  import slwm_pkg::*;
#(
  parameter int AW = 5,
  parameter int EW = 6,
  parameter int WMAX = 32,
  parameter int JW = 1 + 1 + AW + EW + ITEM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  slwm_in_if.sink          in_i,
  input  logic [CFG_W-1:0] window_size_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [JW-1:0]    job_o
);

  localparam int CW = (EW > CFG_W) ? EW : CFG_W;

  logic [AW-1:0] wp_q, wp_d;
  logic [EW-1:0] fill_q, fill_d;
  logic [CW-1:0] cfg_ext;
  logic [EW-1:0] ws;
  logic [AW-1:0] wp_cur, slot;
  logic [EW-1:0] fill_cur, slot_inc;
  logic          do_scan;
  slwm_item_t    item;

  // Window size of zero acts as one, anything above the ring depth saturates.
  always_comb begin
    cfg_ext = CW'(window_size_i);
    if (cfg_ext == '0) begin
      ws = EW'(1);
    end else if (cfg_ext > CW'(WMAX)) begin
      ws = EW'(WMAX);
    end else begin
      ws = EW'(cfg_ext);
    end
  end

  always_comb begin
    wp_cur   = in_i.first_of_sequence ? '0 : wp_q;
    fill_cur = in_i.first_of_sequence ? '0 : fill_q;
    // pointer left past the window after a shrink restarts at slot 0
    slot     = (EW'(wp_cur) >= ws) ? '0 : wp_cur;
    slot_inc = EW'(slot) + EW'(1);
    wp_d     = (slot_inc == ws) ? '0 : AW'(slot_inc);
    fill_d   = (fill_cur < ws) ? fill_cur + EW'(1) : fill_cur;
    do_scan  = !(fill_d < ws);
    item.hash = in_i.hash_value;
    item.low  = in_i.low_byte;
    item.tag  = in_i.position_tag;
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign job_o      = {in_i.first_of_sequence, do_scan, slot, ws, item};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (push_o) begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* rtl/slwm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module slwm_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         nonempty_o,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] store_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign nonempty_o = (count_q != 2'd0);
  assign pop_data_o = store_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

/* rtl/slwm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwm_back
// Writes each word into the window ring, scans the ring one slot a cycle
// for the smallest hash, and emits the minimum when its tag is new.
// ----------------------------------------------------------------------------
module slwm_back
  import slwm_pkg::*;
#(
  parameter int AW = 5,
  parameter int EW = 6,
  parameter int WMAX = 32,
  parameter int JW = 1 + 1 + AW + EW + ITEM_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          nonempty_i,
  input  logic [JW-1:0] job_i,
  output logic          pop_o,
  slwm_out_if.source    out_o
);

  slwm_state_e   state_q, state_d;

  logic [ITEM_W-1:0] ring_mem [WMAX];

  logic [JW-1:0] job_q;
  slwm_item_t    job_item;
  logic [EW-1:0] job_ws;
  logic [AW-1:0] job_slot;
  logic          job_scan;
  logic          job_first;

  logic [AW-1:0] idx_q;
  logic          rvld_q;
  logic [AW-1:0] ridx_q;
  slwm_item_t    rdata_q;
  slwm_item_t    best_q;
  logic [TAG_W-1:0] last_tag_q;

  slwm_item_t    out_q;
  logic          out_valid_q;

  logic          mem_we, rd_en, out_load, emit, out_free, scan_end;

  assign job_item  = slwm_item_t'(job_q[ITEM_W-1:0]);
  assign job_ws    = job_q[ITEM_W +: EW];
  assign job_slot  = job_q[ITEM_W+EW +: AW];
  assign job_scan  = job_q[ITEM_W+EW+AW];
  assign job_first = job_q[JW-1];

  assign scan_end = (EW'(idx_q) == job_ws - EW'(1));
  assign emit     = (best_q.tag != last_tag_q);
  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (nonempty_i) state_d = ST_WRITE;
      ST_WRITE:  state_d = job_scan ? ST_SCAN : ST_IDLE;
      ST_SCAN:   if (scan_end) state_d = ST_LAST;
      ST_LAST:   state_d = ST_DECIDE;
      ST_DECIDE: if (!emit || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:   pop_o    = nonempty_i;
      ST_WRITE:  mem_we   = 1'b1;
      ST_SCAN:   rd_en    = 1'b1;
      ST_LAST:   ;
      ST_DECIDE: out_load = emit && out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[job_slot] <= job_item;
    end
    if (rd_en) begin
      rdata_q <= slwm_item_t'(ring_mem[idx_q]);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    ridx_q <= idx_q;
    // strict less-than keeps the lowest slot on equal hashes
    if (rvld_q && ((ridx_q == '0) || (rdata_q.hash < best_q.hash))) begin
      best_q <= rdata_q;
    end
    if (out_load) begin
      out_q <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rvld_q      <= 1'b0;
      last_tag_q  <= TAG_ALL_ONES;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_en;
      if (state_q == ST_WRITE) begin
        idx_q <= '0;
      end else if (rd_en && !scan_end) begin
        idx_q <= idx_q + AW'(1);
      end
      if (state_q == ST_WRITE && job_first) begin
        last_tag_q <= TAG_ALL_ONES;
      end else if (out_load) begin
        last_tag_q <= best_q.tag;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.min_hash         = out_q.hash;
  assign out_o.min_low_byte     = out_q.low;
  assign out_o.min_position_tag = out_q.tag;

endmodule

/* rtl/sliding_window_minimizer_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimizer_select
// Each input word passes the two-entry queue and is written into the window
// ring; for a word that triggers a scan the ring is scanned one slot a cycle
// for the smallest hash; the back part takes no new word until it is done.
// Reset: pointer and fill count clear, last tag all ones, window size 16;
// ring contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_minimizer_select
  import slwm_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slwm_cfg_if.sink   cfg_i,
  slwm_in_if.sink    in_i,
  slwm_out_if.source out_o
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW = $clog2(WINDOW_MAX + 1);
  localparam int JW = 1 + 1 + AW + EW + ITEM_W;

  logic [CFG_W-1:0] window_size_q;
  logic             push, full, pop, nonempty;
  logic [JW-1:0]    push_job, pop_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      window_size_q <= cfg_i.window_size;
    end
  end

  slwm_front #(
    .AW   (AW),
    .EW   (EW),
    .WMAX (WINDOW_MAX),
    .JW   (JW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .window_size_i (window_size_q),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  slwm_queue #(
    .W (JW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_data_o  (pop_job)
  );

  slwm_back #(
    .AW   (AW),
    .EW   (EW),
    .WMAX (WINDOW_MAX),
    .JW   (JW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .nonempty_i (nonempty),
    .job_i      (pop_job),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
